// ----- hdl/lcg_pkg.sv -----
// Shared types, constants and reset markers for the level-to-color gradient.
package lcg_pkg;

    localparam int unsigned MARKER_SLOTS_DEF = 4;
    localparam int unsigned LEVEL_BITS_DEF   = 16;
    localparam int unsigned QUEUE_DEPTH_DEF  = 4;

    localparam int unsigned CHANNELS   = 3;
    localparam int unsigned CHAN_BITS  = 8;
    localparam int unsigned COLOR_BITS = CHANNELS * CHAN_BITS;
    localparam int unsigned QUOT_BITS  = CHAN_BITS;
    localparam int unsigned COUNT_BITS = 3;

    // channel slots inside a color word, matching the marker entry packing
    localparam int unsigned CH_RED   = 2;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_BLUE  = 0;

    // configuration register indexes
    localparam int unsigned REG_MARKER_COUNT = 0;
    localparam int unsigned REG_MARKER_BASE  = 1;

    localparam logic [COUNT_BITS-1:0] MARKER_COUNT_RESET = 3'd4;

    typedef logic [CHANNELS-1:0][CHAN_BITS-1:0] rgb_t;

    localparam rgb_t COLOR_WHITE = {CHAN_BITS'(255), CHAN_BITS'(255), CHAN_BITS'(255)};

    // per-channel interpolation job: start color, magnitude of the step, direction
    typedef struct packed {
        logic [CHAN_BITS-1:0] base;
        logic [CHAN_BITS-1:0] delta;
        logic                 neg;
    } chan_t;

    localparam int unsigned CHAN_JOB_BITS = $bits(chan_t);

    typedef chan_t [CHANNELS-1:0] chan_set_t;

    // reset marker levels in Q1.15
    function automatic logic [31:0] def_level(input int unsigned slot);
        logic [31:0] lvl;
        case (slot)
            0:       lvl = 32'd0;
            1:       lvl = 32'd9830;
            2:       lvl = 32'd24576;
            3:       lvl = 32'd32768;
            default: lvl = 32'd0;
        endcase
        return lvl;
    endfunction

    function automatic rgb_t def_color(input int unsigned slot);
        rgb_t col;
        case (slot)
            0:       col = 24'h6496FF;
            1:       col = 24'h64FF64;
            2:       col = 24'hFFFF64;
            3:       col = 24'hC83232;
            default: col = '0;
        endcase
        return col;
    endfunction

endpackage

// ----- hdl/lcg_front.sv -----
// Front end: marker registers, level classification and segment selection.
module lcg_front #(
    parameter int unsigned MARKER_SLOTS = lcg_pkg::MARKER_SLOTS_DEF,
    parameter int unsigned LEVEL_BITS   = lcg_pkg::LEVEL_BITS_DEF,
    parameter int unsigned CFG_IDX_W    = $clog2(MARKER_SLOTS + 1)
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // configuration writes
    input  logic                                      cfg_valid,
    input  logic [CFG_IDX_W-1:0]                      cfg_index,
    input  logic [lcg_pkg::COLOR_BITS+LEVEL_BITS-1:0] cfg_data,
    // incoming levels
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic [LEVEL_BITS-1:0]                     in_level,
    // classified jobs toward the queue
    output logic                                      job_valid,
    input  logic                                      job_ready,
    output logic                                      job_bypass,
    output lcg_pkg::rgb_t                             job_color,
    output logic [LEVEL_BITS-1:0]                     job_off,
    output logic [LEVEL_BITS-1:0]                     job_span,
    output lcg_pkg::chan_set_t                        job_chans
);

    localparam int unsigned N_W = $clog2(MARKER_SLOTS + 1);

    logic [lcg_pkg::COUNT_BITS-1:0] marker_count_reg;
    logic [LEVEL_BITS-1:0]          lvl_reg [0:MARKER_SLOTS-1];
    lcg_pkg::rgb_t                  col_reg [0:MARKER_SLOTS-1];

    logic                    valid_reg;
    logic                    bypass_reg, bypass_next;
    lcg_pkg::rgb_t           color_reg, color_next;
    logic [LEVEL_BITS-1:0]   off_reg, off_next;
    logic [LEVEL_BITS-1:0]   span_reg, span_next;
    lcg_pkg::chan_set_t      chans_reg, chans_next;

    logic [N_W-1:0]          n_used;
    logic [LEVEL_BITS-1:0]   last_lvl;
    lcg_pkg::rgb_t           last_col;
    logic                    seg_hit;
    logic [LEVEL_BITS-1:0]   seg_l1, seg_l2;
    lcg_pkg::rgb_t           seg_c1, seg_c2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_count_reg <= lcg_pkg::MARKER_COUNT_RESET;
            for (int i = 0; i < MARKER_SLOTS; i++)
            begin
                lvl_reg[i] <= LEVEL_BITS'(lcg_pkg::def_level(i));
                col_reg[i] <= lcg_pkg::def_color(i);
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_IDX_W'(lcg_pkg::REG_MARKER_COUNT))
            begin
                marker_count_reg <= cfg_data[lcg_pkg::COUNT_BITS-1:0];
            end
            for (int i = 0; i < MARKER_SLOTS; i++)
            begin
                if (cfg_index == CFG_IDX_W'(lcg_pkg::REG_MARKER_BASE + i))
                begin
                    lvl_reg[i] <= cfg_data[lcg_pkg::COLOR_BITS +: LEVEL_BITS];
                    col_reg[i] <= cfg_data[lcg_pkg::COLOR_BITS-1:0];
                end
            end
        end
    end

    // clamp the count to the slots present
    assign n_used = (32'(marker_count_reg) > MARKER_SLOTS) ? N_W'(MARKER_SLOTS)
                                                           : N_W'(marker_count_reg);

    always_comb
    begin
        last_lvl = lvl_reg[0];
        last_col = col_reg[0];
        for (int i = 0; i < MARKER_SLOTS; i++)
        begin
            if (32'(n_used) == i + 1)
            begin
                last_lvl = lvl_reg[i];
                last_col = col_reg[i];
            end
        end
    end

    // scan downward so the lowest matching segment wins
    always_comb
    begin
        seg_hit = 1'b0;
        seg_l1  = lvl_reg[0];
        seg_l2  = lvl_reg[0];
        seg_c1  = col_reg[0];
        seg_c2  = col_reg[0];
        for (int i = MARKER_SLOTS - 2; i >= 0; i--)
        begin
            if ((32'(n_used) >= i + 2) && (in_level >= lvl_reg[i])
                && (in_level <= lvl_reg[i+1]))
            begin
                seg_hit = 1'b1;
                seg_l1  = lvl_reg[i];
                seg_l2  = lvl_reg[i+1];
                seg_c1  = col_reg[i];
                seg_c2  = col_reg[i+1];
            end
        end
    end

    always_comb
    begin
        bypass_next = 1'b1;
        color_next  = lcg_pkg::COLOR_WHITE;
        off_next    = in_level - seg_l1;
        span_next   = seg_l2 - seg_l1;
        for (int c = 0; c < lcg_pkg::CHANNELS; c++)
        begin
            chans_next[c].base = seg_c1[c];
            if (seg_c2[c] >= seg_c1[c])
            begin
                chans_next[c].delta = seg_c2[c] - seg_c1[c];
                chans_next[c].neg   = 1'b0;
            end
            else
            begin
                chans_next[c].delta = seg_c1[c] - seg_c2[c];
                chans_next[c].neg   = 1'b1;
            end
        end
        if (n_used == '0)
        begin
            bypass_next = 1'b1;
        end
        else if (in_level <= lvl_reg[0])
        begin
            color_next = col_reg[0];
        end
        else if (in_level >= last_lvl)
        begin
            color_next = last_col;
        end
        else if (seg_hit)
        begin
            // a zero-width segment gives its start color
            if (seg_l2 == seg_l1)
            begin
                color_next = seg_c1;
            end
            else
            begin
                bypass_next = 1'b0;
            end
        end
    end

    assign in_ready = !valid_reg || job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            bypass_reg <= bypass_next;
            color_reg  <= color_next;
            off_reg    <= off_next;
            span_reg   <= span_next;
            chans_reg  <= chans_next;
        end
    end

    assign job_valid  = valid_reg;
    assign job_bypass = bypass_reg;
    assign job_color  = color_reg;
    assign job_off    = off_reg;
    assign job_span   = span_reg;
    assign job_chans  = chans_reg;

endmodule

// ----- hdl/lcg_queue.sv -----
// Short register queue between the classifier and the interpolation pipeline.
module lcg_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = lcg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/lcg_back.sv -----
// Back end: scaled offset multiply, pipelined restoring divide, color assembly.
module lcg_back #(
    parameter int unsigned LEVEL_BITS = lcg_pkg::LEVEL_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  logic                  job_bypass,
    input  lcg_pkg::rgb_t         job_color,
    input  logic [LEVEL_BITS-1:0] job_off,
    input  logic [LEVEL_BITS-1:0] job_span,
    input  lcg_pkg::chan_set_t    job_chans,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lcg_pkg::rgb_t         out_color
);

    localparam int unsigned STEPS = lcg_pkg::QUOT_BITS;
    localparam int unsigned NUM_W = LEVEL_BITS + lcg_pkg::QUOT_BITS;
    localparam int unsigned CH    = lcg_pkg::CHANNELS;
    localparam int unsigned CB    = lcg_pkg::CHAN_BITS;

    // stage 0 holds the numerator, stage k has k quotient bits resolved
    logic [STEPS:0]              valid_reg;
    logic                        bypass_reg [0:STEPS];
    lcg_pkg::rgb_t               color_reg  [0:STEPS];
    logic [LEVEL_BITS-1:0]       span_reg   [0:STEPS];
    logic [CB-1:0]               base_reg   [0:STEPS][0:CH-1];
    logic                        neg_reg    [0:STEPS][0:CH-1];
    logic [NUM_W-1:0]            rem_reg    [0:STEPS][0:CH-1];
    logic [lcg_pkg::QUOT_BITS-1:0] quo_reg  [0:STEPS][0:CH-1];

    logic [NUM_W-1:0]            div_sh     [0:STEPS-1];
    logic                        fits       [0:STEPS-1][0:CH-1];
    logic [NUM_W-1:0]            num_next   [0:CH-1];

    logic                        out_valid_reg;
    lcg_pkg::rgb_t               out_color_reg, out_color_next;
    logic                        advance;

    assign advance   = !out_valid_reg || out_ready;
    assign job_ready = advance;

    // rounding toward the lower value: add span-1 when the channel falls, so its step rounds up
    always_comb
    begin
        for (int c = 0; c < CH; c++)
        begin
            num_next[c] = NUM_W'(job_off) * NUM_W'(job_chans[c].delta)
                        + (job_chans[c].neg ? NUM_W'(job_span) - 1'b1 : '0);
        end
    end

    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            div_sh[k] = NUM_W'(span_reg[k]) << (STEPS - 1 - k);
            for (int c = 0; c < CH; c++)
            begin
                fits[k][c] = (rem_reg[k][c] >= div_sh[k]);
            end
        end
    end

    always_comb
    begin
        out_color_next = color_reg[STEPS];
        if (!bypass_reg[STEPS])
        begin
            for (int c = 0; c < CH; c++)
            begin
                out_color_next[c] = neg_reg[STEPS][c]
                                  ? base_reg[STEPS][c] - quo_reg[STEPS][c]
                                  : base_reg[STEPS][c] + quo_reg[STEPS][c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg     <= {valid_reg[STEPS-1:0], job_valid};
            out_valid_reg <= valid_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            bypass_reg[0] <= job_bypass;
            color_reg[0]  <= job_color;
            span_reg[0]   <= job_span;
            for (int c = 0; c < CH; c++)
            begin
                base_reg[0][c] <= job_chans[c].base;
                neg_reg[0][c]  <= job_chans[c].neg;
                rem_reg[0][c]  <= num_next[c];
                quo_reg[0][c]  <= '0;
            end
            for (int k = 0; k < STEPS; k++)
            begin
                bypass_reg[k+1] <= bypass_reg[k];
                color_reg[k+1]  <= color_reg[k];
                span_reg[k+1]   <= span_reg[k];
                for (int c = 0; c < CH; c++)
                begin
                    base_reg[k+1][c] <= base_reg[k][c];
                    neg_reg[k+1][c]  <= neg_reg[k][c];
                    rem_reg[k+1][c]  <= fits[k][c] ? rem_reg[k][c] - div_sh[k]
                                                   : rem_reg[k][c];
                    quo_reg[k+1][c]  <= {quo_reg[k][c][lcg_pkg::QUOT_BITS-2:0],
                                         fits[k][c]};
                end
            end
            out_color_reg <= out_color_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_color = out_color_reg;

endmodule

// ----- hdl/level_to_color_gradient.sv -----
// Top level of the level-to-color gradient: front end, job queue and interpolation back end.
// Takes one meter level per cycle and returns one RGB color per cycle, in order, when
// the output is not stalled. A level passes the classification register, the job
// queue, the register after the offset-times-color-step multiply, the restoring divider
// stages that resolve one quotient bit per stage, and the output register. Levels are
// unsigned Q1.15; markers are used in slot order, a level at or below the first or at or
// above the last used marker takes that marker's color, and white is given when no marker
// is set or no segment holds the level. Marker registers may be rewritten only while no
// level is in flight; configuration writes are always accepted.
module level_to_color_gradient #(
    parameter int unsigned MARKER_SLOTS = lcg_pkg::MARKER_SLOTS_DEF,
    parameter int unsigned LEVEL_BITS   = lcg_pkg::LEVEL_BITS_DEF,
    parameter int unsigned QUEUE_DEPTH  = lcg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // meter_level
    input  logic [((LEVEL_BITS+7)/8)*8-1:0]           s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // red [7:0], green [15:8], blue [23:16]
    output logic [lcg_pkg::COLOR_BITS-1:0]            m_tdata,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [$clog2(MARKER_SLOTS+1)-1:0]         cfg_index,
    input  logic [lcg_pkg::COLOR_BITS+LEVEL_BITS-1:0] cfg_data
);

    localparam int unsigned JOB_W = 1 + lcg_pkg::COLOR_BITS + 2 * LEVEL_BITS
                                  + lcg_pkg::CHANNELS * lcg_pkg::CHAN_JOB_BITS;

    logic                  f_valid, f_ready;
    logic                  f_bypass;
    lcg_pkg::rgb_t         f_color;
    logic [LEVEL_BITS-1:0] f_off, f_span;
    lcg_pkg::chan_set_t    f_chans;

    logic                  b_valid, b_ready;
    logic [JOB_W-1:0]      b_job;

    lcg_pkg::rgb_t         out_color;

    assign cfg_ready = 1'b1;

    lcg_front #(
        .MARKER_SLOTS (MARKER_SLOTS),
        .LEVEL_BITS   (LEVEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_level   (s_tdata[LEVEL_BITS-1:0]),
        .job_valid  (f_valid),
        .job_ready  (f_ready),
        .job_bypass (f_bypass),
        .job_color  (f_color),
        .job_off    (f_off),
        .job_span   (f_span),
        .job_chans  (f_chans)
    );

    lcg_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_bypass, f_color, f_off, f_span, f_chans}),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_job)
    );

    lcg_back #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (b_valid),
        .job_ready  (b_ready),
        .job_bypass (b_job[JOB_W-1]),
        .job_color  (b_job[JOB_W-2 -: lcg_pkg::COLOR_BITS]),
        .job_off    (b_job[JOB_W-2-lcg_pkg::COLOR_BITS -: LEVEL_BITS]),
        .job_span   (b_job[JOB_W-2-lcg_pkg::COLOR_BITS-LEVEL_BITS -: LEVEL_BITS]),
        .job_chans  (b_job[lcg_pkg::CHANNELS*lcg_pkg::CHAN_JOB_BITS-1:0]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_color  (out_color)
    );

    assign m_tdata = {out_color[lcg_pkg::CH_BLUE], out_color[lcg_pkg::CH_GREEN],
                      out_color[lcg_pkg::CH_RED]};

endmodule
